### rtl/core/kevt_pkg.sv
// ----------------------------------------------------------------------------
// kevt_pkg
// Shared types, key codes and escape sequence table for the key event
// to terminal byte converter.
// ----------------------------------------------------------------------------
`default_nettype none

package kevt_pkg;

    localparam logic [15:0] VK_IME_COMPOSE = 16'h00E5;
    localparam logic [15:0] VK_SPACE_KEY   = 16'h0020;
    localparam logic [15:0] VK_PAGE_UP     = 16'h0021;
    localparam logic [15:0] VK_PAGE_DOWN   = 16'h0022;
    localparam logic [15:0] VK_END         = 16'h0023;
    localparam logic [15:0] VK_HOME        = 16'h0024;
    localparam logic [15:0] VK_LEFT        = 16'h0025;
    localparam logic [15:0] VK_UP          = 16'h0026;
    localparam logic [15:0] VK_RIGHT       = 16'h0027;
    localparam logic [15:0] VK_DOWN        = 16'h0028;
    localparam logic [15:0] VK_DELETE      = 16'h002E;

    localparam logic [15:0] WCH_SPACE = 16'h0020;
    localparam logic [15:0] WCH_CR    = 16'h000D;

    localparam int MOD_ALT_R  = 0;
    localparam int MOD_ALT_L  = 1;
    localparam int MOD_CTRL_R = 2;
    localparam int MOD_CTRL_L = 3;
    localparam int MOD_SHIFT  = 4;

    localparam logic [20:0] CP_PLANE1 = 21'h010000;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        key_down;
        logic [15:0] virtual_key;
        logic [15:0] unicode_unit;
        logic [4:0]  modifier_state;
        logic        last_in_batch;
    } t_key_event;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_term_byte;

    typedef enum logic {
        CMD_UTF8,
        CMD_SEQ
    } t_cmd_kind;

    typedef enum logic [3:0] {
        SEQ_CTRL_ENTER,
        SEQ_SHIFT_ENTER,
        SEQ_UP,
        SEQ_DOWN,
        SEQ_RIGHT,
        SEQ_LEFT,
        SEQ_HOME,
        SEQ_END,
        SEQ_DELETE,
        SEQ_PAGE_UP,
        SEQ_PAGE_DOWN
    } t_seq;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [20:0] cp;
        t_seq        seq;
        logic [2:0]  len;
    } t_cmd;

    // byte 0 sits in the top slot
    function automatic logic [6:0][7:0] seq_text(input t_seq s);
        logic [6:0][7:0] t;
        t = '0;
        case (s)
            SEQ_CTRL_ENTER:  t = {8'h1B, "[13;5u"};
            SEQ_SHIFT_ENTER: t = {8'h1B, "[13;2u"};
            SEQ_UP:          t = {8'h1B, "[A", 32'h0};
            SEQ_DOWN:        t = {8'h1B, "[B", 32'h0};
            SEQ_RIGHT:       t = {8'h1B, "[C", 32'h0};
            SEQ_LEFT:        t = {8'h1B, "[D", 32'h0};
            SEQ_HOME:        t = {8'h1B, "[H", 32'h0};
            SEQ_END:         t = {8'h1B, "[F", 32'h0};
            SEQ_DELETE:      t = {8'h1B, "[3~", 24'h0};
            SEQ_PAGE_UP:     t = {8'h1B, "[5~", 24'h0};
            SEQ_PAGE_DOWN:   t = {8'h1B, "[6~", 24'h0};
            default:         t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] seq_len(input t_seq s);
        logic [2:0] n;
        case (s)
            SEQ_CTRL_ENTER, SEQ_SHIFT_ENTER:       n = 3'd7;
            SEQ_DELETE, SEQ_PAGE_UP, SEQ_PAGE_DOWN: n = 3'd4;
            default:                               n = 3'd3;
        endcase
        return n;
    endfunction

    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] n;
        priority if (cp < 21'h80) begin
            n = 3'd1;
        end else if (cp < 21'h800) begin
            n = 3'd2;
        end else if (cp < CP_PLANE1) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

### rtl/core/kevt_queue.sv
// ----------------------------------------------------------------------------
// kevt_queue
// Short command queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module kevt_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  kevt_pkg::t_cmd   i_cmd,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_empty,
    output kevt_pkg::t_cmd   o_cmd
);
    import kevt_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wptr, n_wptr;
    logic [QUEUE_AW-1:0] r_rptr, n_rptr;
    logic [QUEUE_CW-1:0] r_count, n_count;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

endmodule

`default_nettype wire

### rtl/core/kevt_front.sv
// ----------------------------------------------------------------------------
// kevt_front
// Accepts key events, tracks surrogate and IME state, and turns each
// press that yields output into a UTF-8 or escape sequence command.
// ----------------------------------------------------------------------------
`default_nettype none

module kevt_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  kevt_pkg::t_key_event i_key,
    output logic                 o_push,
    output kevt_pkg::t_cmd       o_cmd,
    input  wire                  i_full
);
    import kevt_pkg::*;

    logic [15:0] r_pending, n_pending;
    logic        r_armed, n_armed;
    logic        accept;
    logic        emit;
    logic        ctrl, shift, no_mods;
    logic        is_high, is_low;
    logic [15:0] wch;
    logic [20:0] cp;
    t_cmd        cmd;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign wch     = i_key.unicode_unit;
    assign ctrl    = i_key.modifier_state[MOD_CTRL_L] || i_key.modifier_state[MOD_CTRL_R];
    assign shift   = i_key.modifier_state[MOD_SHIFT];
    assign no_mods = (i_key.modifier_state == '0);
    assign is_high = (wch >= 16'hD800) && (wch <= 16'hDBFF);
    assign is_low  = (wch >= 16'hDC00) && (wch <= 16'hDFFF);

    always_comb begin
        n_pending = r_pending;
        n_armed   = r_armed;
        emit      = 1'b0;
        cp        = {5'd0, wch};
        cmd.kind  = CMD_UTF8;
        cmd.cp    = cp;
        cmd.seq   = SEQ_UP;
        cmd.len   = 3'd1;
        if (accept && i_key.key_down) begin
            if (i_key.virtual_key == VK_IME_COMPOSE) begin
                n_armed = 1'b1;
            end else if (wch != '0) begin
                if (r_armed && i_key.virtual_key == VK_SPACE_KEY && wch == WCH_SPACE
                    && no_mods) begin
                    n_armed   = 1'b0;
                    n_pending = '0;
                end else if (is_high) begin
                    n_pending = wch;
                end else begin
                    emit      = 1'b1;
                    n_pending = '0;
                    if (is_low && r_pending != '0) begin
                        cp = CP_PLANE1 + {1'b0, r_pending[9:0], wch[9:0]};
                    end
                    cmd.cp  = cp;
                    cmd.len = utf8_len(cp);
                    if (!(is_low && r_pending != '0) && wch == WCH_CR && (ctrl || shift)) begin
                        cmd.kind = CMD_SEQ;
                        cmd.seq  = ctrl ? SEQ_CTRL_ENTER : SEQ_SHIFT_ENTER;
                        cmd.len  = seq_len(cmd.seq);
                    end
                    if (wch < 16'h0080) begin
                        n_armed = 1'b0;
                    end
                end
            end else begin
                n_pending = '0;
                n_armed   = 1'b0;
                cmd.kind  = CMD_SEQ;
                emit      = 1'b1;
                case (i_key.virtual_key)
                    VK_UP:        cmd.seq = SEQ_UP;
                    VK_DOWN:      cmd.seq = SEQ_DOWN;
                    VK_RIGHT:     cmd.seq = SEQ_RIGHT;
                    VK_LEFT:      cmd.seq = SEQ_LEFT;
                    VK_HOME:      cmd.seq = SEQ_HOME;
                    VK_END:       cmd.seq = SEQ_END;
                    VK_DELETE:    cmd.seq = SEQ_DELETE;
                    VK_PAGE_UP:   cmd.seq = SEQ_PAGE_UP;
                    VK_PAGE_DOWN: cmd.seq = SEQ_PAGE_DOWN;
                    default:      emit    = 1'b0;
                endcase
                cmd.len = seq_len(cmd.seq);
            end
        end
        if (accept && i_key.last_in_batch) begin
            n_pending = '0;
            n_armed   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_armed   <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_armed   <= n_armed;
        end
    end

    assign o_push = emit;
    assign o_cmd  = cmd;

endmodule

`default_nettype wire

### rtl/core/kevt_back.sv
// ----------------------------------------------------------------------------
// kevt_back
// Expands queued commands into bytes, one per cycle while the receiver is
// ready, into an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module kevt_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_empty,
    input  kevt_pkg::t_cmd       i_cmd,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire                  i_ready,
    output kevt_pkg::t_term_byte o_byte
);
    import kevt_pkg::*;

    t_cmd            r_cmd;
    logic            r_cmd_valid;
    logic [2:0]      r_idx;
    logic            r_out_valid;
    t_term_byte      r_out;
    logic            produce;
    logic            last;
    logic [2:0]      pos;
    logic [6:0][7:0] txt;
    logic [7:0]      cur_byte;
    logic [7:0]      lead;
    logic [7:0]      cont;

    assign produce = r_cmd_valid && (!r_out_valid || i_ready);
    assign last    = (r_idx == r_cmd.len - 3'd1);
    assign o_pop   = !i_empty && (!r_cmd_valid || (produce && last));
    assign pos     = r_cmd.len - 3'd1 - r_idx;
    assign txt     = seq_text(r_cmd.seq);

    always_comb begin
        case (pos[1:0])
            2'd0:    cont = {2'b10, r_cmd.cp[5:0]};
            2'd1:    cont = {2'b10, r_cmd.cp[11:6]};
            default: cont = {2'b10, r_cmd.cp[17:12]};
        endcase
        case (r_cmd.len)
            3'd1:    lead = r_cmd.cp[7:0];
            3'd2:    lead = {3'b110, r_cmd.cp[10:6]};
            3'd3:    lead = {4'b1110, r_cmd.cp[15:12]};
            default: lead = {5'b11110, r_cmd.cp[20:18]};
        endcase
        unique case (r_cmd.kind)
            CMD_UTF8: cur_byte = (r_idx == '0) ? lead : cont;
            CMD_SEQ:  cur_byte = txt[3'd6 - r_idx];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cmd_valid <= 1'b1;
                r_idx       <= '0;
            end else if (produce) begin
                r_cmd_valid <= !last;
                r_idx       <= r_idx + 3'd1;
            end
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (produce) begin
            r_out.out_byte  <= cur_byte;
            r_out.last_byte <= last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out;

endmodule

`default_nettype wire

### rtl/core/key_event_to_terminal_bytes.sv
// ----------------------------------------------------------------------------
// key_event_to_terminal_bytes
// Keyboard event to terminal byte stream converter.
//
// Input channel i_valid/o_ready carries one key event (i_key). Output
// channel o_valid/i_ready carries one byte at a time (o_byte) with
// last_byte set on the final byte caused by an event; events that cause
// nothing produce no output.
// The front stage takes an event every cycle while the two-entry command
// queue has room; surrogate and IME state update at acceptance.
// The back stage emits one byte per cycle while the receiver is ready; an
// event yields 1 to 7 bytes, and sustained throughput is set by that byte
// sequencer. The first byte passes the queue, command and output registers.
// When the receiver stalls, the output register holds its byte, the queue
// fills, and o_ready drops once it is full.
// Synchronous active-low reset clears pending surrogate, IME flag, queue
// and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module key_event_to_terminal_bytes (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  kevt_pkg::t_key_event i_key,
    output logic                 o_valid,
    input  wire                  i_ready,
    output kevt_pkg::t_term_byte o_byte
);
    import kevt_pkg::*;

    logic push, pop, full, empty;
    t_cmd front_cmd, queue_cmd;

    kevt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_key   (i_key),
        .o_push  (push),
        .o_cmd   (front_cmd),
        .i_full  (full)
    );

    kevt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    kevt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_byte  (o_byte)
    );

endmodule

`default_nettype wire

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for key_event_to_terminal_bytes. A short list of
// directed key events (text extremes, surrogate pairs, enter variants,
// navigation keys, IME confirm drop, batch end) is followed by random key
// event sequences. Every request is encoded by a local byte predictor, and
// each output byte is compared against the oldest predicted byte. Both
// channels stall at random, with one calm phase and one full drain.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kevt_pkg::*;

    localparam int          RANDOM_PRESSES = 400;
    localparam int          IDLE_LIMIT     = 3000;
    localparam int          FROM_ENCODER   = -1;
    localparam logic [7:0]  ESC            = 8'h1B;

    typedef struct {
        t_key_event      ev;
        int              n_bytes;
        logic [0:6][7:0] bytes;
    } key_row;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       i_ready = 1'b0;
    t_key_event i_key   = '0;
    logic       o_ready;
    logic       o_valid;
    t_term_byte o_byte;

    t_term_byte  term_bytes_due[$];
    key_row      dir_rows[$];
    logic [15:0] held_high_half = '0;
    bit          ime_armed      = 1'b0;
    bit          calm           = 1'b0;
    int          errors         = 0;
    int          presses        = 0;
    int          idle_cycles    = 0;
    int          stall_left     = 0;

    key_event_to_terminal_bytes u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_key   (i_key),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_byte  (o_byte)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic t_key_event mk_key(bit d, logic [15:0] vk, logic [15:0] u,
                                          logic [4:0] m, bit l);
        t_key_event e;
        e.key_down       = d;
        e.virtual_key    = vk;
        e.unicode_unit   = u;
        e.modifier_state = m;
        e.last_in_batch  = l;
        return e;
    endfunction

    function automatic void add_row(t_key_event ev, int n, logic [0:6][7:0] b);
        key_row r;
        r.ev      = ev;
        r.n_bytes = n;
        r.bytes   = b;
        dir_rows.push_back(r);
    endfunction

    function automatic int utf8_bytes(input logic [20:0] cp, output logic [0:6][7:0] s);
        s = '0;
        if (cp < 21'h80) begin
            s[0] = cp[7:0];
            return 1;
        end else if (cp < 21'h800) begin
            s[0] = {3'b110, cp[10:6]};
            s[1] = {2'b10, cp[5:0]};
            return 2;
        end else if (cp < 21'h10000) begin
            s[0] = {4'b1110, cp[15:12]};
            s[1] = {2'b10, cp[11:6]};
            s[2] = {2'b10, cp[5:0]};
            return 3;
        end
        s[0] = {5'b11110, cp[20:18]};
        s[1] = {2'b10, cp[17:12]};
        s[2] = {2'b10, cp[11:6]};
        s[3] = {2'b10, cp[5:0]};
        return 4;
    endfunction

    // updates surrogate/IME state, returns byte count
    function automatic int encode_key(input t_key_event ev, output logic [0:6][7:0] s);
        int          n;
        logic [15:0] u;
        logic [15:0] vk;
        logic [4:0]  m;
        logic [20:0] cp;
        n  = 0;
        s  = '0;
        u  = ev.unicode_unit;
        vk = ev.virtual_key;
        m  = ev.modifier_state;
        if (ev.key_down) begin
            if (vk == VK_IME_COMPOSE) begin
                ime_armed = 1'b1;
            end else if (u != 16'h0) begin
                if (ime_armed && vk == VK_SPACE_KEY && u == WCH_SPACE && m == 5'b0) begin
                    ime_armed      = 1'b0;
                    held_high_half = '0;
                end else if (u >= 16'hD800 && u <= 16'hDBFF) begin
                    held_high_half = u;
                end else begin
                    if (u >= 16'hDC00 && u <= 16'hDFFF && held_high_half != 16'h0) begin
                        cp = 21'h10000 + ((21'(held_high_half) - 21'hD800) << 10)
                             + (21'(u) - 21'hDC00);
                        n  = utf8_bytes(cp, s);
                    end else if (u == WCH_CR && (m[MOD_CTRL_L] || m[MOD_CTRL_R])) begin
                        s = {ESC, "[13;5u"};
                        n = 7;
                    end else if (u == WCH_CR && m[MOD_SHIFT]) begin
                        s = {ESC, "[13;2u"};
                        n = 7;
                    end else begin
                        n = utf8_bytes({5'b0, u}, s);
                    end
                    held_high_half = '0;
                    if (ime_armed && u < 16'h80) ime_armed = 1'b0;
                end
            end else begin
                held_high_half = '0;
                ime_armed      = 1'b0;
                n              = 3;
                case (vk)
                    VK_UP:        s = {ESC, "[A", 32'h0};
                    VK_DOWN:      s = {ESC, "[B", 32'h0};
                    VK_RIGHT:     s = {ESC, "[C", 32'h0};
                    VK_LEFT:      s = {ESC, "[D", 32'h0};
                    VK_HOME:      s = {ESC, "[H", 32'h0};
                    VK_END:       s = {ESC, "[F", 32'h0};
                    VK_DELETE:    begin s = {ESC, "[3~", 24'h0}; n = 4; end
                    VK_PAGE_UP:   begin s = {ESC, "[5~", 24'h0}; n = 4; end
                    VK_PAGE_DOWN: begin s = {ESC, "[6~", 24'h0}; n = 4; end
                    default:      n = 0;
                endcase
            end
        end
        if (ev.last_in_batch) begin
            held_high_half = '0;
            ime_armed      = 1'b0;
        end
        return n;
    endfunction

    // n_fixed >= 0 means the row carries its own expected bytes
    task automatic send_key(t_key_event ev, int n_fixed, logic [0:6][7:0] fixed);
        int              gap;
        int              n;
        logic [0:6][7:0] s;
        t_term_byte      b;
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            i_key   <= mk_key(1'($urandom()), 16'($urandom()), 16'($urandom()),
                              5'($urandom()), 1'($urandom()));
            repeat (gap) @(posedge i_clk);
        end
        n = encode_key(ev, s);
        if (n_fixed >= 0) begin
            n = n_fixed;
            s = fixed;
        end
        for (int k = 0; k < n; k++) begin
            b.out_byte  = s[k];
            b.last_byte = (k == n - 1);
            term_bytes_due.push_back(b);
        end
        if (ev.key_down) presses++;
        i_valid <= 1'b1;
        i_key   <= ev;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_rand(t_key_event ev);
        send_key(ev, FROM_ENCODER, '0);
    endtask

    function automatic logic [15:0] rand_nav_vk();
        case ($urandom_range(0, 8))
            0: return VK_UP;
            1: return VK_DOWN;
            2: return VK_RIGHT;
            3: return VK_LEFT;
            4: return VK_HOME;
            5: return VK_END;
            6: return VK_DELETE;
            7: return VK_PAGE_UP;
            default: return VK_PAGE_DOWN;
        endcase
    endfunction

    function automatic bit rand_last();
        return ($urandom_range(0, 9) == 0);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            stall_left = 0;
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_term_byte want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (term_bytes_due.size() == 0) begin
                    $error("unexpected byte: out_byte %h last_byte %b",
                           o_byte.out_byte, o_byte.last_byte);
                    errors++;
                end else begin
                    want = term_bytes_due.pop_front();
                    if (o_byte.out_byte !== want.out_byte) begin
                        $error("out_byte: expected %h, got %h", want.out_byte, o_byte.out_byte);
                        errors++;
                    end
                    if (o_byte.last_byte !== want.last_byte) begin
                        $error("last_byte: expected %b, got %b",
                               want.last_byte, o_byte.last_byte);
                        errors++;
                    end
                end
            end
            if ((o_valid && i_ready) || (i_valid && o_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        t_key_event  ev;
        logic [15:0] u;
        int          r;
        bit          drained;

        add_row(mk_key(1, 16'h41, 16'h41, 5'h00, 0), 1, {8'h41, 48'h0});
        add_row(mk_key(1, 16'h00, 16'h80, 5'h00, 0), 2, {8'hC2, 8'h80, 40'h0});
        add_row(mk_key(1, 16'hFFFF, 16'hFFFF, 5'h1F, 0), 3, {24'hEFBFBF, 32'h0});
        add_row(mk_key(1, 16'h00, 16'hD800, 5'h00, 0), 0, '0);
        add_row(mk_key(1, 16'h00, 16'hDC00, 5'h00, 0), 4, {32'hF0908080, 24'h0});
        add_row(mk_key(1, 16'h00, 16'hDBFF, 5'h00, 0), 0, '0);
        add_row(mk_key(1, 16'h00, 16'hDFFF, 5'h00, 0), 4, {32'hF48FBFBF, 24'h0});
        add_row(mk_key(1, 16'h00, 16'hDC00, 5'h00, 0), 3, {24'hEDB080, 32'h0});
        add_row(mk_key(1, 16'h00, 16'hD83D, 5'h00, 0), 0, '0);
        add_row(mk_key(1, 16'h42, 16'h62, 5'h00, 0), FROM_ENCODER, '0);
        add_row(mk_key(1, 16'h0D, WCH_CR, 5'h08, 0), 7, {ESC, "[13;5u"});
        add_row(mk_key(1, 16'h0D, WCH_CR, 5'h10, 0), 7, {ESC, "[13;2u"});
        add_row(mk_key(1, 16'h0D, WCH_CR, 5'h14, 0), FROM_ENCODER, '0);
        add_row(mk_key(1, VK_UP, 16'h0, 5'h00, 0), 3, {ESC, "[A", 32'h0});
        add_row(mk_key(1, VK_DOWN, 16'h0, 5'h00, 0), 3, {ESC, "[B", 32'h0});
        add_row(mk_key(1, VK_RIGHT, 16'h0, 5'h00, 0), 3, {ESC, "[C", 32'h0});
        add_row(mk_key(1, VK_LEFT, 16'h0, 5'h00, 0), 3, {ESC, "[D", 32'h0});
        add_row(mk_key(1, VK_HOME, 16'h0, 5'h00, 0), 3, {ESC, "[H", 32'h0});
        add_row(mk_key(1, VK_END, 16'h0, 5'h00, 0), 3, {ESC, "[F", 32'h0});
        add_row(mk_key(1, VK_DELETE, 16'h0, 5'h00, 0), 4, {ESC, "[3~", 24'h0});
        add_row(mk_key(1, VK_PAGE_UP, 16'h0, 5'h00, 0), 4, {ESC, "[5~", 24'h0});
        add_row(mk_key(1, VK_PAGE_DOWN, 16'h0, 5'h00, 0), 4, {ESC, "[6~", 24'h0});
        add_row(mk_key(1, 16'h70, 16'h0, 5'h00, 0), 0, '0);
        add_row(mk_key(1, 16'h00, 16'hD800, 5'h00, 0), 0, '0);
        add_row(mk_key(1, VK_IME_COMPOSE, 16'h0, 5'h00, 0), 0, '0);
        add_row(mk_key(0, 16'h41, 16'h41, 5'h00, 1), 0, '0);
        add_row(mk_key(1, 16'h00, 16'hDC00, 5'h00, 0), FROM_ENCODER, '0);
        add_row(mk_key(1, VK_SPACE_KEY, WCH_SPACE, 5'h00, 0), FROM_ENCODER, '0);
        add_row(mk_key(1, VK_IME_COMPOSE, 16'h1234, 5'h00, 0), 0, '0);
        add_row(mk_key(1, VK_SPACE_KEY, WCH_SPACE, 5'h00, 0), 0, '0);
        add_row(mk_key(1, VK_IME_COMPOSE, 16'h0, 5'h00, 0), 0, '0);
        add_row(mk_key(1, VK_SPACE_KEY, WCH_SPACE, 5'h10, 0), FROM_ENCODER, '0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) send_key(dir_rows[i].ev, dir_rows[i].n_bytes, dir_rows[i].bytes);

        presses = 0;
        drained = 1'b0;
        while (presses < RANDOM_PRESSES) begin
            calm = (presses >= 150 && presses < 230);
            if (!drained && presses >= 300) begin
                drained = 1'b1;
                i_valid <= 1'b0;
                do @(posedge i_clk); while (term_bytes_due.size() != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 30) begin
                case ($urandom_range(0, 3))
                    0: u = 16'($urandom_range(1, 16'h7F));
                    1: u = 16'($urandom_range(16'h80, 16'h7FF));
                    2: u = 16'($urandom_range(16'h800, 16'hFFFF));
                    default: u = 16'($urandom());
                endcase
                ev = mk_key(1, $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 255)),
                            u, 5'($urandom()), rand_last());
                send_rand(ev);
            end else if (r < 45) begin
                send_rand(mk_key(1, 16'($urandom()), 16'($urandom_range(16'hD800, 16'hDBFF)),
                                 5'($urandom()), rand_last()));
                if ($urandom_range(0, 4) == 0) begin
                    send_rand(mk_key(1, 16'h41, 16'($urandom_range(1, 16'hD7FF)),
                                     5'($urandom()), 0));
                end
                send_rand(mk_key(1, 16'($urandom()), 16'($urandom_range(16'hDC00, 16'hDFFF)),
                                 5'($urandom()), rand_last()));
            end else if (r < 55) begin
                send_rand(mk_key(1, 16'h0D, WCH_CR, 5'($urandom()), rand_last()));
            end else if (r < 72) begin
                ev = mk_key(1, rand_nav_vk(), 16'h0, 5'($urandom()), rand_last());
                if ($urandom_range(0, 3) == 0) ev.virtual_key = 16'($urandom());
                send_rand(ev);
            end else if (r < 87) begin
                send_rand(mk_key(1, VK_IME_COMPOSE,
                                 $urandom_range(0, 1) ? 16'($urandom()) : 16'h0,
                                 5'($urandom()), rand_last()));
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6:
                        ev = mk_key(1, VK_SPACE_KEY, WCH_SPACE, 5'h00, rand_last());
                    7: ev = mk_key(1, VK_SPACE_KEY, WCH_SPACE, 5'($urandom_range(1, 31)), 0);
                    8: ev = mk_key(1, 16'h41, 16'($urandom_range(16'h80, 16'hFFFF)), 5'h00, 0);
                    default: ev = mk_key(1, VK_SPACE_KEY, 16'($urandom()), 5'h00, 0);
                endcase
                send_rand(ev);
                if ($urandom_range(0, 2) == 0) begin
                    send_rand(mk_key(1, VK_SPACE_KEY, WCH_SPACE, 5'h00, 0));
                end
            end else begin
                ev = mk_key(0, 16'($urandom()), 16'($urandom()), 5'($urandom()),
                            1'($urandom()));
                send_rand(ev);
            end
        end

        calm = 1'b0;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (term_bytes_due.size() != 0);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
